@@ rtl/stsub_pkg.sv @@
package stsub_pkg;

	// Width of one coordinate on the ports.
	localparam int COORD_W = 16;
	// Magnitude of an edge sum, its square, and the squared length.
	localparam int MAG_W   = COORD_W + 1;
	localparam int SQ_W    = 2 * MAG_W - 1;
	localparam int LEN_W   = SQ_W + 1;

	// Position of the last result of an input within its run of four.
	localparam logic [1:0] LAST_SUB = 2'd3;

	// One vertex: x in the lowest bits, then y, then z.
	typedef logic [2:0][COORD_W-1:0] vec_t;
	// One triangle: first vertex in the lowest bits.
	typedef vec_t [2:0] tri_t;

	// Shared pipeline control.
	typedef struct packed {
		logic en;
	} pipe_ctl_t;

endpackage

@@ rtl/sphere_triangle_subdivider.sv @@
// Channel   Dir  Payload                                          Framing
// s_*       in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z       one input triangle
// m_*       out  tdata: out0_x..z out1_x..z out2_x..z            four results per input,
//                                                                 tlast = last_triangle
// From input transfer to the first result, an item passes the edge stages, the
// midpoint lane stages and the holding register. Results leave at one per cycle
// while the receiver is ready, four per input, so the output port sets the input rate.
// Each midpoint lane has FRAC_BITS + 1 register stages, one result bit each.
// Reset clears the valid bits and the output counter only.
// A stall on the output freezes the whole pipeline once its last stage is full.
module sphere_triangle_subdivider import stsub_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // out0_x, out0_y, out0_z, out1_x, ..., out2_z
	output logic         m_tlast
);

	localparam int DEPTH = FRAC_BITS + 4;

	pipe_ctl_t  ctl;
	tri_t       vin;
	logic [DEPTH-1:0] vld_q;
	tri_t       vtx_q [DEPTH];
	vec_t       mab, mbc, mca;
	tri_t       hv_q;
	vec_t       hab_q, hbc_q, hca_q;
	logic       hold_v_q;
	logic [1:0] cnt_q;
	logic       load;
	tri_t       tri_out;

	assign vin = s_tdata;

	// The holding register takes a new item when empty or on its last transfer.
	assign load     = !hold_v_q || (m_tready && cnt_q == LAST_SUB);
	assign ctl.en   = !vld_q[DEPTH-1] || load;
	assign s_tready = ctl.en;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Input vertices travel alongside the midpoint lanes.
	for (genvar i = 0; i < DEPTH; i++) begin : g_vtx
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				vtx_q[i] <= (i == 0) ? vin : vtx_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	stsub_edge #(.FRAC_BITS(FRAC_BITS)) u_ab (
		.clk(clk), .ctl(ctl), .va(vin[0]), .vb(vin[1]), .mid(mab)
	);
	stsub_edge #(.FRAC_BITS(FRAC_BITS)) u_bc (
		.clk(clk), .ctl(ctl), .va(vin[1]), .vb(vin[2]), .mid(mbc)
	);
	stsub_edge #(.FRAC_BITS(FRAC_BITS)) u_ca (
		.clk(clk), .ctl(ctl), .va(vin[2]), .vb(vin[0]), .mid(mca)
	);

	// Holding register control: valid flag and position in the run of four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			hold_v_q <= vld_q[DEPTH-1];
			cnt_q    <= '0;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	// Holding register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			hv_q  <= vtx_q[DEPTH-1];
			hab_q <= mab;
			hbc_q <= mbc;
			hca_q <= mca;
		end
	end

	// Merge the vertices and midpoints into the current sub-triangle.
	always_comb begin
		case (cnt_q)
			2'd0:    tri_out = {hca_q, hab_q, hv_q[0]};
			2'd1:    tri_out = {hbc_q, hv_q[1], hab_q};
			2'd2:    tri_out = {hbc_q, hca_q, hab_q};
			default: tri_out = {hv_q[2], hbc_q, hca_q};
		endcase
	end

	assign m_tvalid = hold_v_q;
	assign m_tdata  = tri_out;
	assign m_tlast  = (cnt_q == LAST_SUB);

	// A run of four results is not broken by a gap.
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("result run broken before its last transfer");

	// A finished item held at the pipeline end while stalled is kept.
	a_tail_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DEPTH-1] && !s_tready |=> vld_q[DEPTH-1])
		else $error("stalled pipeline lost its last stage");

	// After the last result with nothing behind it, the output goes idle.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !vld_q[DEPTH-1] |=> !m_tvalid)
		else $error("result shown without an item behind it");

endmodule

@@ rtl/stsub_lane.sv @@
module stsub_lane import stsub_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  pipe_ctl_t           ctl,
	input  logic [LEN_W-1:0]    len,
	input  logic [SQ_W-1:0]     sq,
	input  logic                neg,
	output logic [COORD_W-1:0]  coord
);

	localparam int W     = 2 * FRAC_BITS + 40;
	localparam int STEPS = FRAC_BITS + 1;

	// Stage inputs and registers, one entry per result bit.
	logic [W-1:0]         c_in [STEPS];
	logic [W-1:0]         d_in [STEPS];
	logic [W-1:0]         r_in [STEPS];
	logic [FRAC_BITS:0]   q_in [STEPS];
	logic [LEN_W-1:0]     l_in [STEPS];
	logic                 n_in [STEPS];
	logic [W-1:0]         c_q  [STEPS];
	logic [W-1:0]         d_q  [STEPS];
	logic [W-1:0]         r_q  [STEPS];
	logic [FRAC_BITS:0]   q_q  [STEPS];
	logic [LEN_W-1:0]     l_q  [STEPS];
	logic                 n_q  [STEPS];

	// Each stage decides one bit of q, MSB first. With u = 2q - 1 the test is
	// u^2 * len <= 4 * sq * 2^(2F); c tracks (2q)^2 * len and d tracks 2q * len.
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = FRAC_BITS - j;
		logic [W-1:0] ct;
		logic [W-1:0] dt;
		logic [W:0]   lhs;
		logic [W:0]   rhs;
		logic         ok;

		if (j == 0) begin : g_first
			assign c_in[j] = '0;
			assign d_in[j] = '0;
			assign q_in[j] = '0;
			assign r_in[j] = W'(sq) << (2 * FRAC_BITS + 2);
			assign l_in[j] = len;
			assign n_in[j] = neg;
		end else begin : g_next
			assign c_in[j] = c_q[j-1];
			assign d_in[j] = d_q[j-1];
			assign q_in[j] = q_q[j-1];
			assign r_in[j] = r_q[j-1];
			assign l_in[j] = l_q[j-1];
			assign n_in[j] = n_q[j-1];
		end

		assign ct  = c_in[j] + (d_in[j] << (K + 2)) + (W'(l_in[j]) << (2 * K + 2));
		assign dt  = d_in[j] + (W'(l_in[j]) << (K + 1));
		assign lhs = {1'b0, ct} + (W + 1)'(l_in[j]);
		assign rhs = {1'b0, r_in[j]} + {dt, 1'b0};
		// Once q reaches the full scale no lower bit may be added.
		assign ok  = (lhs <= rhs) && !q_in[j][FRAC_BITS];

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				c_q[j] <= ok ? ct : c_in[j];
				d_q[j] <= ok ? dt : d_in[j];
				q_q[j] <= ok ? (q_in[j] | ((FRAC_BITS + 1)'(1) << K)) : q_in[j];
				r_q[j] <= r_in[j];
				l_q[j] <= l_in[j];
				n_q[j] <= n_in[j];
			end
		end
	end

	// Apply the sign; a zero-length sum gives zero.
	logic signed [FRAC_BITS+1:0] mag_sv;
	logic signed [FRAC_BITS+1:0] val_sv;

	assign mag_sv = $signed({1'b0, q_q[STEPS-1]});
	assign val_sv = n_q[STEPS-1] ? -mag_sv : mag_sv;
	assign coord  = (l_q[STEPS-1] == '0) ? '0 : COORD_W'(val_sv);

endmodule

@@ rtl/stsub_edge.sv @@
module stsub_edge import stsub_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  vec_t      va,
	input  vec_t      vb,
	output vec_t      mid
);

	logic [MAG_W-1:0] mag_s1 [3];
	logic             neg_s1 [3];
	logic [SQ_W-1:0]  sq_s2  [3];
	logic             neg_s2 [3];
	logic [SQ_W-1:0]  sq_s3  [3];
	logic             neg_s3 [3];
	logic [LEN_W-1:0] len_s3;

	// Edge sum per coordinate, split into magnitude and sign, then squared.
	for (genvar i = 0; i < 3; i++) begin : g_coord
		logic signed [MAG_W-1:0] sum;

		assign sum = $signed({va[i][COORD_W-1], va[i]}) + $signed({vb[i][COORD_W-1], vb[i]});

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				neg_s1[i] <= sum[MAG_W-1];
				mag_s1[i] <= sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
				sq_s2[i]  <= SQ_W'(mag_s1[i] * mag_s1[i]);
				neg_s2[i] <= neg_s1[i];
				sq_s3[i]  <= sq_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
		end

		stsub_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.len    (len_s3),
			.sq     (sq_s3[i]),
			.neg    (neg_s3[i]),
			.coord  (mid[i])
		);
	end

	// Squared length of the edge sum.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			len_s3 <= LEN_W'(sq_s2[0]) + LEN_W'(sq_s2[1]) + LEN_W'(sq_s2[2]);
		end
	end

endmodule

@@ sim/tb_sphere_triangle_subdivider.sv @@
module tb_sphere_triangle_subdivider import stsub_pkg::*;;

	localparam int FRAC = 14;
	localparam int LATENCY = FRAC + 5;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_TRIANGLES = 217;
	localparam int ONE = 1 << FRAC;

	// One expected output transfer: three vertices and the last flag.
	typedef struct {
		logic [143:0] vertices;
		logic         last;
	} subtri_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic         m_tlast;

	int  error_count = 0;
	int  idle_cycles = 0;
	bit  hold_off = 1'b0;

	sphere_triangle_subdivider #(.FRAC_BITS(FRAC)) dut (.*);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// Projects an edge sum onto the unit sphere, rounding to nearest, ties away from zero.
	function automatic vec_t project_edge_sum(input logic signed [16:0] sum [3]);
		logic [127:0] len;
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [16:0]  mag [3];
		longint unsigned lo, hi, mid, odd;
		vec_t res;
		len = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = sum[i] < 0 ? -sum[i] : sum[i];
			len += 128'(mag[i]) * 128'(mag[i]);
		end
		for (int i = 0; i < 3; i++) begin
			lo = 0;
			if (len != 0) begin
				hi = ONE;
				rhs = (128'(mag[i]) * 128'(mag[i]) * 4) << (2 * FRAC);
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					odd = 2 * mid - 1;
					lhs = 128'(odd) * 128'(odd) * len;
					if (lhs <= rhs) lo = mid;
					else hi = mid - 1;
				end
			end
			res[i] = sum[i] < 0 ? 16'(-lo) : 16'(lo);
		end
		return res;
	endfunction

	class subdivision_scoreboard;
		subtri_t pending[$];

		// Appends one expected sub-triangle at the tail of the queue.
		function void queue_expected(input subtri_t item);
			pending = {pending, item};
		endfunction

		// Notes one accepted input triangle and queues its four sub-triangles.
		function void note_input(input logic [143:0] data);
			vec_t v [3];
			vec_t m_ab, m_bc, m_ca;
			logic signed [16:0] s [3];
			for (int k = 0; k < 3; k++) v[k] = data[k*48 +: 48];
			for (int i = 0; i < 3; i++)
				s[i] = 17'(signed'(v[0][i])) + 17'(signed'(v[1][i]));
			m_ab = project_edge_sum(s);
			for (int i = 0; i < 3; i++)
				s[i] = 17'(signed'(v[1][i])) + 17'(signed'(v[2][i]));
			m_bc = project_edge_sum(s);
			for (int i = 0; i < 3; i++)
				s[i] = 17'(signed'(v[2][i])) + 17'(signed'(v[0][i]));
			m_ca = project_edge_sum(s);
			queue_expected('{{m_ca, m_ab, v[0]}, 1'b0});
			queue_expected('{{m_bc, v[1], m_ab}, 1'b0});
			queue_expected('{{m_bc, m_ca, m_ab}, 1'b0});
			queue_expected('{{v[2], m_bc, m_ca}, 1'b1});
		endfunction

		// Checks one output transfer field by field against the oldest expectation.
		task check_result(input logic [143:0] data, input logic last);
			subtri_t exp_t;
			if (pending.size() == 0) begin
				report_mismatch("output transfer with nothing expected");
				return;
			end
			exp_t = pending.pop_front();
			for (int f = 0; f < 9; f++)
				if (data[f*16 +: 16] !== exp_t.vertices[f*16 +: 16])
					report_mismatch($sformatf("vertex %0d coord %0d got %h want %h",
						f / 3, f % 3, data[f*16 +: 16], exp_t.vertices[f*16 +: 16]));
			if (last !== exp_t.last)
				report_mismatch($sformatf("tlast got %b want %b", last, exp_t.last));
		endtask
	endclass

	subdivision_scoreboard board = new();

	function automatic logic [15:0] random_coord();
		case ($urandom_range(0, 5))
			0: return 16'(ONE);
			1: return 16'(-ONE);
			2: return 16'(0);
			3: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 2 * ONE) - ONE);
		endcase
	endfunction

	// Random point near the unit sphere, built from an axis-scaled direction.
	function automatic logic [47:0] sphere_vertex();
		int c [3];
		real n;
		for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 2000) - 1000;
		n = $sqrt(real'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]));
		if (n == 0.0) return {16'd0, 16'd0, 16'(ONE)};
		return {16'($rtoi(c[2] * ONE / n)), 16'($rtoi(c[1] * ONE / n)),
			16'($rtoi(c[0] * ONE / n))};
	endfunction

	// Offers one triangle after a random gap and waits for its transfer.
	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_triangle(input logic [143:0] data);
		int gap;
		gap = $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= data;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_input(data);
		@(negedge clk);
	endtask

	// Back-to-back offers with no gap, used while the receiver holds off.
	task automatic send_burst(input int count);
		for (int n = 0; n < count; n++) begin
			s_tdata <= {sphere_vertex(), sphere_vertex(), sphere_vertex()};
			s_tvalid <= 1'b1;
			do @(posedge clk); while (!s_tready);
			board.note_input(s_tdata);
			@(negedge clk);
		end
	endtask

	// Receiver: random stalls, stretches with none, and one long hold-off.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (150) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				if (wait_n > 0) begin
					m_tready <= 1'b0;
					repeat (wait_n) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [47:0] p, q;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Axis-aligned octant, then the extremes and degenerate cases.
		send_triangle({16'(ONE), 16'd0, 16'd0, 16'd0, 16'(ONE), 16'd0, 16'd0, 16'd0, 16'(ONE)});
		send_triangle({16'(-ONE), 16'd0, 16'd0, 16'd0, 16'(-ONE), 16'd0, 16'd0, 16'd0,
			16'(-ONE)});
		// Opposite vertices make a zero-length midpoint.
		send_triangle({16'd0, 16'd0, 16'(ONE), 16'd0, 16'd0, 16'(-ONE), 16'd0, 16'(ONE), 16'd0});
		send_triangle('0);
		send_triangle({9{16'h7fff}});
		send_triangle({9{16'h8000}});
		send_triangle({3{16'h8000, 16'h7fff, 16'h8000}});
		send_triangle({9{16'h0001}});
		send_triangle({9{16'hffff}});
		send_triangle({16'd1, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0});
		send_triangle({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 16'haaaa, 16'h5555});
		// Identical vertices.
		p = sphere_vertex();
		send_triangle({p, p, p});
		q = sphere_vertex();
		send_triangle({q, p, q});

		// Long receiver hold-off while the sender keeps offering.
		hold_off = 1'b1;
		send_burst(30);

		for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
			if ($urandom_range(0, 3) != 0)
				send_triangle({sphere_vertex(), sphere_vertex(), sphere_vertex()});
			else begin
				logic [143:0] d;
				for (int f = 0; f < 9; f++) d[f*16 +: 16] = random_coord();
				send_triangle(d);
			end
		end
		s_tvalid <= 1'b0;

		wait (board.pending.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/stsub_pkg.sv
rtl/stsub_lane.sv
rtl/stsub_edge.sv
rtl/sphere_triangle_subdivider.sv
sim/tb_sphere_triangle_subdivider.sv
